/* rtl/core/fdsc_pkg.sv */
`timescale 1ns / 1ps

package fdsc_pkg;

  localparam int DataW   = 32;
  localparam int RateW   = 16;
  localparam int CfgIdxW = 2;
  localparam int FracW   = 16;

  localparam logic [CfgIdxW-1:0] CFG_TICK_RATE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_RATE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBUG_RATE = 2'd2;

  localparam logic [DataW-1:0] TICK_RATE_RST  = 32'd10000000;
  localparam logic [RateW-1:0] SPEED_RATE_RST = 16'd256;
  localparam logic [RateW-1:0] DEBUG_RATE_RST = 16'd256;

  typedef struct packed {
    logic accept;
    logic update;
    logic check;
    logic div_start;
    logic div_avg;
    logic avg_take;
    logic sec_take;
    logic mul_a;
    logic mul_b;
    logic load_out;
  } fdsc_cmd_t;

  typedef struct packed {
    logic clamp;
    logic div_done;
  } fdsc_status_t;

endpackage

/* rtl/core/frame_delta_spike_clamp_unit.sv */
// An item runs through one division to a valid result, or two when it is clamped, each a
// 48-step pass through the shared serial divider.
// The next item is accepted from the cycle after its result is loaded into the output register,
// so no new item is taken while one is in flight or while its result waits on a full output register.
// Reset is asynchronous and active low; it empties the history and restores the rate registers.
`timescale 1ns / 1ps

module frame_delta_spike_clamp_unit #(
  parameter int RING_DEPTH = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fdsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fdsc_pkg::DataW-1:0]   cfg_data_i,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  // [31:0] elapsed_ticks
  input  logic [31:0]                  s_tdata_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  // [31:0] delta_seconds, [63:32] scaled_delta
  output logic [63:0]                  m_tdata_o,
  // [0] was_clamped
  output logic                         m_tuser_o
);

  import fdsc_pkg::*;

  fdsc_cmd_t        cmd;
  fdsc_status_t     status;
  logic [DataW-1:0] delta_seconds;
  logic [DataW-1:0] scaled_delta;

  fdsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fdsc_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .elapsed_ticks_i (s_tdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .delta_seconds_o (delta_seconds),
    .scaled_delta_o  (scaled_delta),
    .was_clamped_o   (m_tuser_o)
  );

  assign m_tdata_o = {scaled_delta, delta_seconds};

endmodule

/* rtl/core/fdsc_divider.sv */
`timescale 1ns / 1ps

module fdsc_divider #(
  parameter int NumW = 48,
  parameter int DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic            fits;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/fdsc_ctrl.sv */
`timescale 1ns / 1ps

module fdsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  fdsc_pkg::fdsc_status_t status_i,
  output fdsc_pkg::fdsc_cmd_t    cmd_o
);

  import fdsc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_UPDATE   = 11'b000_0000_0010,
    S_CHECK    = 11'b000_0000_0100,
    S_SELECT   = 11'b000_0000_1000,
    S_AVG_WAIT = 11'b000_0001_0000,
    S_SEC_GO   = 11'b000_0010_0000,
    S_SEC_WAIT = 11'b000_0100_0000,
    S_MUL_A    = 11'b000_1000_0000,
    S_MUL_B    = 11'b001_0000_0000,
    S_FINISH   = 11'b010_0000_0000,
    S_SPARE    = 11'b100_0000_0000
  } fdsc_state_e;

  fdsc_state_e state_q, state_d;
  logic        m_valid_q, m_valid_d;
  fdsc_cmd_t   cmd;

  always_comb begin
    state_d   = state_q;
    cmd       = '0;
    m_valid_d = m_valid_q & ~m_tready_i;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd.accept = 1'b1;
          state_d    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_d   = S_SELECT;
      end
      S_SELECT: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = status_i.clamp;
        state_d       = status_i.clamp ? S_AVG_WAIT : S_SEC_WAIT;
      end
      S_AVG_WAIT: begin
        if (status_i.div_done) begin
          cmd.avg_take = 1'b1;
          state_d      = S_SEC_GO;
        end
      end
      S_SEC_GO: begin
        cmd.div_start = 1'b1;
        state_d       = S_SEC_WAIT;
      end
      S_SEC_WAIT: begin
        if (status_i.div_done) begin
          cmd.sec_take = 1'b1;
          state_d      = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_d   = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (!m_valid_q || m_tready_i) begin
          cmd.load_out = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign cmd_o      = cmd;

endmodule

/* rtl/core/fdsc_datapath.sv */
`timescale 1ns / 1ps

module fdsc_datapath #(
  parameter int RING_DEPTH = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fdsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fdsc_pkg::DataW-1:0]    cfg_data_i,
  input  logic [fdsc_pkg::DataW-1:0]    elapsed_ticks_i,
  input  fdsc_pkg::fdsc_cmd_t           cmd_i,
  output fdsc_pkg::fdsc_status_t        status_o,
  output logic [fdsc_pkg::DataW-1:0]    delta_seconds_o,
  output logic [fdsc_pkg::DataW-1:0]    scaled_delta_o,
  output logic                          was_clamped_o
);

  import fdsc_pkg::*;

  localparam int IdxW  = $clog2(RING_DEPTH);
  localparam int SumW  = DataW + IdxW;
  localparam int DivNw = (SumW + 1 > DataW + FracW) ? SumW + 1 : DataW + FracW;
  localparam int P1W   = DataW + RateW;
  localparam int ProdW = DataW + IdxW;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);
  localparam logic [IdxW-1:0] HalfCnt = IdxW'(RING_DEPTH / 2);

  logic [DataW-1:0] tick_rate_q;
  logic [RateW-1:0] speed_rate_q;
  logic [RateW-1:0] debug_rate_q;

  logic [DataW-1:0] ring_q [RING_DEPTH];
  logic [DataW-1:0] rd_data_q;

  logic [IdxW-1:0]  wr_idx_q, old_idx_q, held_q;
  logic [SumW-1:0]  sum_q;
  logic             full_q;
  logic [DataW-1:0] elapsed_q;
  logic             clamp_q;
  logic [DataW-1:0] ticks_q;
  logic [DataW-1:0] secs_q;
  logic [P1W-1:0]   p1_q;
  logic [P1W-1:0]   mhi_q;
  logic [2*RateW-1:0] mlo_q;
  logic [DataW-1:0] out_secs_q, out_scaled_q;
  logic             out_clamped_q;

  logic [ProdW-1:0] prod;
  logic [DivNw-1:0] div_num;
  logic [DataW-1:0] div_den;
  logic             div_done;
  logic [DivNw-1:0] div_quo;
  logic [P1W:0]     rate_sum;

  function automatic logic [IdxW-1:0] wrap_next(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q  <= TICK_RATE_RST;
      speed_rate_q <= SPEED_RATE_RST;
      debug_rate_q <= DEBUG_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_RATE:  tick_rate_q  <= cfg_data_i;
        CFG_SPEED_RATE: speed_rate_q <= cfg_data_i[RateW-1:0];
        CFG_DEBUG_RATE: debug_rate_q <= cfg_data_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_q[wr_idx_q] <= elapsed_ticks_i;
      rd_data_q        <= ring_q[old_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      old_idx_q <= '0;
      held_q    <= '0;
      sum_q     <= '0;
    end else if (cmd_i.update) begin
      wr_idx_q <= wrap_next(wr_idx_q);
      if (full_q) begin
        old_idx_q <= wrap_next(old_idx_q);
        held_q    <= LastIdx;
        sum_q     <= sum_q - SumW'(rd_data_q) + SumW'(elapsed_q);
      end else begin
        held_q <= held_q + 1'b1;
        sum_q  <= sum_q + SumW'(elapsed_q);
      end
    end
  end

  assign prod = ProdW'(elapsed_q) * ProdW'(held_q);

  assign div_num = cmd_i.div_avg ? DivNw'({sum_q, 1'b0})
                                 : DivNw'({ticks_q, {FracW{1'b0}}});
  assign div_den = cmd_i.div_avg ? DataW'(held_q) : tick_rate_q;

  fdsc_divider #(
    .NumW(DivNw),
    .DenW(DataW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign rate_sum = {1'b0, mhi_q} + (P1W + 1)'(mlo_q[2*RateW-1:FracW]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elapsed_q <= elapsed_ticks_i;
      full_q    <= held_q >= LastIdx;
    end
    if (cmd_i.check) begin
      clamp_q <= (held_q > HalfCnt) && ({1'b0, prod} >= {sum_q, 1'b0});
      ticks_q <= elapsed_q;
    end
    if (cmd_i.avg_take) begin
      ticks_q <= div_quo[DataW-1:0];
    end
    if (cmd_i.sec_take) begin
      secs_q <= (div_quo > DivNw'({DataW{1'b1}})) ? '1 : div_quo[DataW-1:0];
    end
    if (cmd_i.mul_a) begin
      p1_q <= P1W'(secs_q) * P1W'(speed_rate_q);
    end
    if (cmd_i.mul_b) begin
      mhi_q <= P1W'(p1_q[P1W-1:FracW]) * P1W'(debug_rate_q);
      mlo_q <= (2*RateW)'(p1_q[FracW-1:0]) * (2*RateW)'(debug_rate_q);
    end
    if (cmd_i.load_out) begin
      out_secs_q    <= secs_q;
      out_scaled_q  <= (|rate_sum[P1W:DataW]) ? '1 : rate_sum[DataW-1:0];
      out_clamped_q <= clamp_q;
    end
  end

  assign status_o.clamp    = clamp_q;
  assign status_o.div_done = div_done;
  assign delta_seconds_o   = out_secs_q;
  assign scaled_delta_o    = out_scaled_q;
  assign was_clamped_o     = out_clamped_q;

endmodule

/* verif/frame_delta_spike_clamp_unit_tb.sv */
`timescale 1ns / 1ps

module frame_delta_spike_clamp_unit_tb;
  import fdsc_pkg::*;

  localparam int unsigned HISTORY_SLOTS = 30;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned TARGET_FRAMES = 1550;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] delta_seconds;
    logic [31:0] scaled_delta;
    logic        was_clamped;
  } frame_delta_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_TICK_RATE;
  logic [DataW-1:0]   cfg_data_i = '0;
  logic               s_tvalid_i = 1'b0;
  logic               s_tready_o;
  // [31:0] elapsed_ticks
  logic [31:0]        s_tdata_i = '0;
  logic               m_tvalid_o;
  logic               m_tready_i = 1'b0;
  // [31:0] delta_seconds, [63:32] scaled_delta
  logic [63:0]        m_tdata_o;
  // [0] was_clamped
  logic               m_tuser_o;

  frame_delta_spike_clamp_unit #(
    .RING_DEPTH(HISTORY_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  // Predictor state and its copy of the rate registers.
  logic [31:0] recent_ticks [HISTORY_SLOTS];
  int unsigned ring_wr = 0;
  int unsigned ring_oldest = 0;
  int unsigned ring_fill = 0;
  logic [63:0] ring_total = '0;
  logic [31:0] tick_rate_q = TICK_RATE_RST;
  logic [15:0] speed_rate_q = SPEED_RATE_RST;
  logic [15:0] debug_rate_q = DEBUG_RATE_RST;

  frame_delta_t expected_deltas [$];
  logic [31:0]  pending_ticks [$];
  int unsigned  frames_issued = 0;
  int unsigned  frames_accepted = 0;
  int unsigned  fail_count = 0;
  int unsigned  quiet_cycles = 0;
  logic         in_fire = 1'b0;
  logic         out_fire = 1'b0;
  logic         no_idle = 1'b0;
  int unsigned  hold_requests = 0;
  int unsigned  holds_served = 0;
  int unsigned  hold_left = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_gap = 0;
  frame_delta_t observed;
  frame_delta_t wanted;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic frame_delta_t predict_frame_delta(input logic [31:0] elapsed);
    frame_delta_t res;
    logic [31:0]  ticks;
    logic [63:0]  twice;
    logic [63:0]  quot;
    logic [63:0]  p1;
    logic [63:0]  r;
    ticks = elapsed;
    res.was_clamped = 1'b0;
    if (ring_fill >= HISTORY_SLOTS - 1) begin
      ring_total = ring_total - 64'(recent_ticks[ring_oldest]);
      ring_oldest = (ring_oldest == HISTORY_SLOTS - 1) ? 0 : ring_oldest + 1;
      ring_fill = HISTORY_SLOTS - 2;
    end
    recent_ticks[ring_wr] = elapsed;
    ring_wr = (ring_wr == HISTORY_SLOTS - 1) ? 0 : ring_wr + 1;
    ring_total = ring_total + 64'(elapsed);
    ring_fill = ring_fill + 1;
    if (ring_fill > HISTORY_SLOTS / 2) begin
      twice = ring_total << 1;
      if (64'(elapsed) * 64'(ring_fill) >= twice) begin
        ticks = 32'(twice / 64'(ring_fill));
        res.was_clamped = 1'b1;
      end
    end
    if (tick_rate_q == '0) begin
      res.delta_seconds = '1;
    end else begin
      quot = {16'b0, ticks, 16'b0} / 64'(tick_rate_q);
      res.delta_seconds = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
    end
    p1 = 64'(res.delta_seconds) * 64'(speed_rate_q);
    r = (p1 >> 16) * 64'(debug_rate_q) + (((p1 & 64'hFFFF) * 64'(debug_rate_q)) >> 16);
    res.scaled_delta = (r > 64'hFFFF_FFFF) ? '1 : r[31:0];
    return res;
  endfunction

  function automatic logic [31:0] draw_base();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 200);
      1: return $urandom_range(150000, 180000);
      2: return $urandom_range(32'h0010_0000, 32'h0400_0000);
      default: return $urandom_range(32'h2000_0000, 32'hFFFF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] draw_ticks(input logic [31:0] base);
    int unsigned sel;
    logic [63:0] b;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    b = 64'(base);
    if (sel < 70) begin
      v = b - b / 16 + 64'($urandom_range(0, 32'(b / 8)));
    end else if (sel < 82) begin
      v = b * 64'($urandom_range(2, 12));
    end else if (sel < 92) begin
      v = 64'($urandom);
    end else if (sel < 96) begin
      v = '0;
    end else begin
      v = 64'hFFFF_FFFF;
    end
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [15:0] draw_scale();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd256;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_frame(input logic [31:0] ticks);
    pending_ticks.push_back(ticks);
    frames_issued++;
  endtask

  task automatic settle();
    while (frames_accepted != frames_issued || expected_deltas.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    in_fire <= rst_ni && s_tvalid_i && s_tready_o;
    out_fire <= rst_ni && m_tvalid_o && m_tready_i;
    if (rst_ni && cfg_we_i) begin
      case (cfg_index_i)
        CFG_TICK_RATE: tick_rate_q = cfg_data_i;
        CFG_SPEED_RATE: speed_rate_q = cfg_data_i[15:0];
        CFG_DEBUG_RATE: debug_rate_q = cfg_data_i[15:0];
        default: ;
      endcase
    end
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      expected_deltas.push_back(predict_frame_delta(s_tdata_i));
      frames_accepted++;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      observed.delta_seconds = m_tdata_o[31:0];
      observed.scaled_delta = m_tdata_o[63:32];
      observed.was_clamped = m_tuser_o;
      if (expected_deltas.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Unexpected result: delta %h scaled %h clamped %b",
                   observed.delta_seconds, observed.scaled_delta, observed.was_clamped);
      end else begin
        wanted = expected_deltas.pop_front();
        if (observed.delta_seconds !== wanted.delta_seconds ||
            observed.scaled_delta !== wanted.scaled_delta ||
            observed.was_clamped !== wanted.was_clamped) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Mismatch: expected delta %h scaled %h clamped %b, got %h %h %b",
                     wanted.delta_seconds, wanted.scaled_delta, wanted.was_clamped,
                     observed.delta_seconds, observed.scaled_delta, observed.was_clamped);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The gap before the next frame is drawn when a transaction completes.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid_i || in_fire)) begin
      if (s_tvalid_i) send_gap = no_idle ? 0 : $urandom_range(0, 9);
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid_i <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        s_tdata_i <= pending_ticks.pop_front();
        s_tvalid_i <= 1'b1;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (out_fire) recv_gap = no_idle ? 0 : $urandom_range(0, 9);
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  initial begin
    int unsigned phase;
    logic [31:0] base;
    logic [31:0] rate;
    phase = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With sixteen equal frames held, the seventeenth lands exactly on twice the average.
    repeat (16) queue_frame(32'd1500);
    queue_frame(32'd3200);
    queue_frame(32'hFFFF_FFFF);
    queue_frame(32'd0);
    queue_frame(32'd1);
    settle();

    write_reg(CFG_TICK_RATE, 32'd1);
    write_reg(CFG_SPEED_RATE, 32'h0000_FFFF);
    write_reg(CFG_DEBUG_RATE, 32'h0000_FFFF);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    @(posedge clk_i);
    queue_frame(32'hFFFF_FFFF);
    queue_frame(32'd0);
    queue_frame(32'd1);
    queue_frame(32'd65535);
    queue_frame(32'd65536);

    while (frames_issued < TARGET_FRAMES) begin
      settle();
      if (phase == 0) begin
        write_reg(CFG_TICK_RATE, '0);
      end else if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: rate = 32'd1;
          1: rate = 32'hFFFF_FFFF;
          2: rate = TICK_RATE_RST;
          3: rate = $urandom_range(1, 65535);
          4: rate = $urandom;
          default: rate = '0;
        endcase
        write_reg(CFG_TICK_RATE, rate);
      end
      if ($urandom_range(0, 2) != 0) write_reg(CFG_SPEED_RATE, {16'b0, draw_scale()});
      if ($urandom_range(0, 2) != 0) write_reg(CFG_DEBUG_RATE, {16'b0, draw_scale()});
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, $urandom);
      @(posedge clk_i);
      no_idle = ($urandom_range(0, 3) == 0);
      base = draw_base();
      repeat ($urandom_range(40, 160)) queue_frame(draw_ticks(base));
      if (phase == 0 || $urandom_range(0, 5) == 0) hold_requests++;
      phase++;
    end
    settle();

    if (fail_count == 0 && expected_deltas.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
